// ===== rtl/core/lfu_pkg.sv =====
`default_nettype none

package lfu_pkg;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] value;
        logic [31:0] key;
    } rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_cache_table.sv =====
// lfu_cache_table: key-value cache, least-frequently-used replacement,
// least-recently-used entry chosen among equal counts.
// s_* channel: one access per beat, s_tuser[0] = op (0 get, 1 put),
//   s_tdata = key (bits 31:0) and value (bits 63:32).
// m_* channel: one result per access, m_tuser = hit (bit 0), evicted (bit 1),
//   m_tdata = read_value (bits 31:0) and evicted_key (bits 63:32).
// cfg_* channel: capacity_in_use (5 bits), always ready, write while idle.
// One access at a time: a scan pass reads every entry of the record memory
// to find the key, the victim and a free slot, a decide state chooses the
// action, and a read-modify-write pass updates counts and recency ranks; a
// get miss skips the update pass. The record memory's single read port
// sets the pace. The next access is accepted in the cycle after the result
// is loaded. A finished result sits in the output register; the next
// access is taken meanwhile and, if the receiver still stalls, waits for
// the register to free.
// Reset clears all valid bits and the occupancy and sets capacity to 16;
// entry memories are not cleared.

`default_nettype none

module lfu_cache_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key, value
    input  wire logic [0:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // read_value, evicted_key
    output logic [1:0]       m_tuser,   // hit, evicted
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam logic [IW:0] CNT_N = (IW + 1)'(ENTRIES);

    state_t state_reg, state_next;

    logic [4:0]         cap_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [OW-1:0]      occ_reg;

    logic               in_op_reg;
    logic [31:0]        in_key_reg;
    logic [31:0]        in_val_reg;

    logic [IW:0]        cnt_reg;
    logic               pend_reg;
    logic [IW-1:0]      pidx_reg;

    logic               found_reg;
    logic [IW-1:0]      fidx_reg;
    logic [IW-1:0]      frank_reg;
    logic [31:0]        fval_reg;
    logic               vfound_reg;
    logic [IW-1:0]      vidx_reg;
    logic [31:0]        vcount_reg;
    logic [IW-1:0]      vrank_reg;
    logic [31:0]        vkey_reg;
    logic               free_found_reg;
    logic [IW-1:0]      free_idx_reg;

    logic               do_ev_reg;
    logic               do_ins_reg;
    logic [IW-1:0]      slot_reg;

    logic               res_hit_reg;
    logic [31:0]        res_rd_reg;
    logic               res_ev_reg;
    logic [31:0]        res_evk_reg;

    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic [1:0]         out_user_reg;

    rec_t               rec_mem [ENTRIES];
    logic [IW-1:0]      rank_mem [ENTRIES];
    rec_t               rec_rd_reg;
    logic [IW-1:0]      rank_rd_reg;

    logic               rd_en;
    logic [IW-1:0]      raddr;
    logic               we;
    rec_t               wrec;
    logic [IW-1:0]      wrank;

    logic               in_acc;
    logic               out_load;
    logic [31:0]        cap_ext;
    logic [31:0]        eff_cap;
    logic               need_ev;
    logic               do_ev;
    logic               do_ins;
    logic [IW-1:0]      slot_sel;
    logic               cur_valid;
    logic               key_match;
    logic               better_victim;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // capacity of zero acts as one, capacity above the table size saturates
    always_comb
    begin
        cap_ext = 32'(cap_reg);
        if (cap_ext == 32'd0)
        begin
            eff_cap = 32'd1;
        end
        else if (cap_ext > 32'(ENTRIES))
        begin
            eff_cap = 32'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign need_ev  = (32'(occ_reg) >= eff_cap);
    assign do_ev    = !found_reg && (in_op_reg == OP_PUT) && need_ev && vfound_reg;
    assign do_ins   = !found_reg && (in_op_reg == OP_PUT) && (do_ev || free_found_reg);
    assign slot_sel = (do_ev && (!free_found_reg || vidx_reg < free_idx_reg))
                      ? vidx_reg : free_idx_reg;

    // victim leaves and the new entry takes its slot or the first free one
    always_comb
    begin
        valid_next = valid_reg;
        if (do_ev)
        begin
            valid_next[vidx_reg] = 1'b0;
        end
        if (do_ins)
        begin
            valid_next[slot_sel] = 1'b1;
        end
    end

    assign cur_valid     = valid_reg[pidx_reg];
    assign key_match     = cur_valid && (rec_rd_reg.key == in_key_reg);
    assign better_victim = !vfound_reg || (rec_rd_reg.count < vcount_reg) ||
                           ((rec_rd_reg.count == vcount_reg) && (rank_rd_reg > vrank_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_N && pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (found_reg || do_ins) ? ST_UPD : ST_DONE;
            end
            ST_UPD:
            begin
                if (cnt_reg == CNT_N && pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory control
    always_comb
    begin
        rd_en = 1'b0;
        raddr = cnt_reg[IW-1:0];
        we    = 1'b0;
        unique case (state_reg)
            ST_SCAN:
            begin
                rd_en = (cnt_reg != CNT_N);
            end
            ST_UPD:
            begin
                rd_en = (cnt_reg != CNT_N);
                we    = pend_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // read-modify-write of one entry during the update pass
    always_comb
    begin
        wrec  = rec_rd_reg;
        wrank = rank_rd_reg;
        if (found_reg)
        begin
            if (pidx_reg == fidx_reg)
            begin
                wrank = '0;
                if (rec_rd_reg.count != COUNT_MAX)
                begin
                    wrec.count = rec_rd_reg.count + 32'd1;
                end
                if (in_op_reg == OP_PUT)
                begin
                    wrec.value = in_val_reg;
                end
            end
            else if (cur_valid && rank_rd_reg < frank_reg)
            begin
                wrank = rank_rd_reg + IW'(1);
            end
        end
        else if (do_ins_reg && pidx_reg == slot_reg)
        begin
            wrec.key   = in_key_reg;
            wrec.value = in_val_reg;
            wrec.count = 32'd1;
            wrank      = '0;
        end
        else if (cur_valid)
        begin
            // close the victim's gap, then age for the new entry
            if (do_ev_reg && rank_rd_reg > vrank_reg)
            begin
                wrank = rank_rd_reg;
            end
            else
            begin
                wrank = rank_rd_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rec_mem[pidx_reg]  <= wrec;
            rank_mem[pidx_reg] <= wrank;
        end
        if (rd_en)
        begin
            rec_rd_reg  <= rec_mem[raddr];
            rank_rd_reg <= rank_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= 5'd16;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            pend_reg <= rd_en;
            if (rd_en)
            begin
                cnt_reg <= cnt_reg + (IW + 1)'(1);
            end
            if (state_reg == ST_DECIDE)
            begin
                cnt_reg   <= '0;
                valid_reg <= valid_next;
                if (do_ins && !do_ev)
                begin
                    occ_reg <= occ_reg + OW'(1);
                end
            end
            if (in_acc)
            begin
                cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_op_reg      <= s_tuser[0];
            in_key_reg     <= s_tdata[31:0];
            in_val_reg     <= s_tdata[63:32];
            found_reg      <= 1'b0;
            vfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (rd_en)
        begin
            pidx_reg <= raddr;
        end
        if (state_reg == ST_SCAN && pend_reg)
        begin
            if (!found_reg && key_match)
            begin
                found_reg <= 1'b1;
                fidx_reg  <= pidx_reg;
                frank_reg <= rank_rd_reg;
                fval_reg  <= rec_rd_reg.value;
            end
            if (cur_valid && better_victim)
            begin
                vfound_reg <= 1'b1;
                vidx_reg   <= pidx_reg;
                vcount_reg <= rec_rd_reg.count;
                vrank_reg  <= rank_rd_reg;
                vkey_reg   <= rec_rd_reg.key;
            end
            if (!free_found_reg && !cur_valid)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pidx_reg;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            do_ev_reg   <= do_ev;
            do_ins_reg  <= do_ins;
            slot_reg    <= slot_sel;
            res_hit_reg <= found_reg;
            res_rd_reg  <= (found_reg && in_op_reg == OP_GET) ? fval_reg : 32'd0;
            res_ev_reg  <= do_ev;
            res_evk_reg <= do_ev ? vkey_reg : 32'd0;
        end
        if (out_load)
        begin
            out_data_reg <= {res_evk_reg, res_rd_reg};
            out_user_reg <= {res_ev_reg, res_hit_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and eviction in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (found_reg || do_ins_reg))
        else $error("update pass without action");

endmodule

`default_nettype wire
